// ----- hdl/aesd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesd_pkg
// Shared types, S-box tables and GF(2^8) helpers for the AES-256 decryptor.
// ----------------------------------------------------------------------------
package aesd_pkg;

	localparam int NR      = 14;
	localparam int NK      = 8;
	localparam int SCHED_N = 4 * (NR + 1);
	localparam int CFG_N   = 4;

	typedef logic [127:0] blk_t;
	typedef logic [31:0]  word_t;
	typedef logic [7:0]   sbox_t [256];

	typedef enum logic [1:0] {
		RK_FIRST,
		RK_MID,
		RK_LAST
	} rnd_kind_t;

	typedef struct packed {
		logic vld;
		logic last;
		blk_t blk;
	} item_t;

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] r;
		x = a;
		y = b;
		r = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (y[0]) begin
				r = r ^ x;
			end
			x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
			y = {1'b0, y[7:1]};
		end
		return r;
	endfunction

	function automatic logic [7:0] gf_inv(input logic [7:0] a);
		logic [7:0] sq;
		logic [7:0] r;
		sq = a;
		r  = 8'h01;
		for (int i = 0; i < 7; i++) begin
			sq = gf_mul(sq, sq);
			r  = gf_mul(r, sq);
		end
		return r;
	endfunction

	function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
		return (v << n) | (v >> (8 - n));
	endfunction

	// forward or inverse s-box, built at elaboration
	function automatic sbox_t gen_sbox(input logic inv);
		sbox_t      t;
		logic [7:0] x8;
		logic [7:0] v;
		logic [7:0] s;
		for (int x = 0; x < 256; x++) begin
			x8 = x[7:0];
			v  = gf_inv(x8);
			s  = v ^ rotl8(v, 1) ^ rotl8(v, 2) ^ rotl8(v, 3) ^ rotl8(v, 4) ^ 8'h63;
			if (inv) begin
				t[s] = x8;
			end else begin
				t[x8] = s;
			end
		end
		return t;
	endfunction

	localparam sbox_t SBOX     = gen_sbox(1'b0);
	localparam sbox_t INV_SBOX = gen_sbox(1'b1);

	function automatic word_t sub_word(input word_t w);
		word_t r;
		for (int i = 0; i < 4; i++) begin
			r[8*i +: 8] = SBOX[w[8*i +: 8]];
		end
		return r;
	endfunction

	function automatic logic [7:0] rcon(input logic [2:0] j);
		logic [7:0] r;
		case (j)
			3'd1:    r = 8'h01;
			3'd2:    r = 8'h02;
			3'd3:    r = 8'h04;
			3'd4:    r = 8'h08;
			3'd5:    r = 8'h10;
			3'd6:    r = 8'h20;
			3'd7:    r = 8'h40;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic word_t inv_mix_col(input word_t w);
		logic [7:0] a0;
		logic [7:0] a1;
		logic [7:0] a2;
		logic [7:0] a3;
		word_t      r;
		a0 = w[7:0];
		a1 = w[15:8];
		a2 = w[23:16];
		a3 = w[31:24];
		r[7:0]   = gf_mul(a0, 8'h0e) ^ gf_mul(a1, 8'h0b) ^ gf_mul(a2, 8'h0d) ^ gf_mul(a3, 8'h09);
		r[15:8]  = gf_mul(a0, 8'h09) ^ gf_mul(a1, 8'h0e) ^ gf_mul(a2, 8'h0b) ^ gf_mul(a3, 8'h0d);
		r[23:16] = gf_mul(a0, 8'h0d) ^ gf_mul(a1, 8'h09) ^ gf_mul(a2, 8'h0e) ^ gf_mul(a3, 8'h0b);
		r[31:24] = gf_mul(a0, 8'h0b) ^ gf_mul(a1, 8'h0d) ^ gf_mul(a2, 8'h09) ^ gf_mul(a3, 8'h0e);
		return r;
	endfunction

	function automatic blk_t inv_mix_blk(input blk_t b);
		blk_t r;
		for (int c = 0; c < 4; c++) begin
			r[32*c +: 32] = inv_mix_col(b[32*c +: 32]);
		end
		return r;
	endfunction

	function automatic blk_t inv_shift_sub(input blk_t b);
		blk_t r;
		for (int c = 0; c < 4; c++) begin
			for (int rr = 0; rr < 4; rr++) begin
				r[8*(rr + 4*c) +: 8] = INV_SBOX[b[8*(rr + 4*((c - rr + 4) % 4)) +: 8]];
			end
		end
		return r;
	endfunction

endpackage

// ----- hdl/aesd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesd_if
// Valid/ready channels for ciphertext and plaintext items.
// ----------------------------------------------------------------------------
interface aesd_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] cipher_low;
	logic [63:0] cipher_high;
	logic        last_block;

	modport source (output valid, cipher_low, cipher_high, last_block, input ready);
	modport sink   (input valid, cipher_low, cipher_high, last_block, output ready);
endinterface

interface aesd_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] plain_low;
	logic [63:0] plain_high;
	logic        last_out;

	modport source (output valid, plain_low, plain_high, last_out, input ready);
	modport sink   (input valid, plain_low, plain_high, last_out, output ready);
endinterface

// ----- hdl/aesd_keyexp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesd_keyexp
// Key registers and a one-word-per-cycle key schedule for decryption.
// ----------------------------------------------------------------------------
module aesd_keyexp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [63:0]         cfg_wdata,
	output logic                busy,
	output aesd_pkg::blk_t      rkey [aesd_pkg::NR + 1]
);

	logic [63:0]          key_q [aesd_pkg::CFG_N];
	logic                 busy_q;
	logic [5:0]           cnt_q;
	aesd_pkg::word_t      win_q [aesd_pkg::NK];
	aesd_pkg::blk_t       rk_q [aesd_pkg::NR + 1];
	logic [255:0]         key_all;
	aesd_pkg::word_t      w_prev;
	aesd_pkg::word_t      t_word;
	aesd_pkg::word_t      w_new;
	aesd_pkg::word_t      w_store;
	logic [3:0]           rnd;

	assign key_all = {key_q[3], key_q[2], key_q[1], key_q[0]};
	assign w_prev  = win_q[aesd_pkg::NK - 1];
	assign rnd     = cnt_q[5:2];

	always_comb begin
		case (cnt_q[2:0])
			3'd0:    t_word = aesd_pkg::sub_word({w_prev[7:0], w_prev[31:8]})
				^ {24'h0, aesd_pkg::rcon(cnt_q[5:3])};
			3'd4:    t_word = aesd_pkg::sub_word(w_prev);
			default: t_word = w_prev;
		endcase
		if (cnt_q < 6'(aesd_pkg::NK)) begin
			w_new = key_all[32*cnt_q[2:0] +: 32];
		end else begin
			w_new = win_q[0] ^ t_word;
		end
		// equivalent inverse cipher: middle round keys go through inverse mix
		if (rnd != 4'd0 && rnd != 4'(aesd_pkg::NR)) begin
			w_store = aesd_pkg::inv_mix_col(w_new);
		end else begin
			w_store = w_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd0;
			for (int i = 0; i < aesd_pkg::CFG_N; i++) begin
				key_q[i] <= 64'd0;
			end
		end else if (cfg_we) begin
			key_q[cfg_index] <= cfg_wdata;
			busy_q           <= 1'b1;
			cnt_q            <= 6'd0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'(aesd_pkg::SCHED_N - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && !cfg_we) begin
			for (int j = 0; j < aesd_pkg::NK - 1; j++) begin
				win_q[j] <= win_q[j + 1];
			end
			win_q[aesd_pkg::NK - 1]    <= w_new;
			rk_q[rnd][32*cnt_q[1:0] +: 32] <= w_store;
		end
	end

	assign busy = busy_q;
	assign rkey = rk_q;

endmodule

// ----- hdl/aesd_round.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesd_round
// One registered stage of the inverse cipher: key add, full or final round.
// ----------------------------------------------------------------------------
module aesd_round (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  aesd_pkg::rnd_kind_t  kind,
	input  aesd_pkg::blk_t       rkey,
	input  aesd_pkg::item_t      din,
	output aesd_pkg::item_t      dout
);

	logic           vld_s1;
	logic           last_s1;
	aesd_pkg::blk_t blk_s1;
	aesd_pkg::blk_t ss;
	aesd_pkg::blk_t nxt;

	always_comb begin
		ss = aesd_pkg::inv_shift_sub(din.blk);
		case (kind)
			aesd_pkg::RK_FIRST: nxt = din.blk ^ rkey;
			aesd_pkg::RK_MID:   nxt = aesd_pkg::inv_mix_blk(ss) ^ rkey;
			aesd_pkg::RK_LAST:  nxt = ss ^ rkey;
			default:            nxt = din.blk ^ rkey;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= din.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s1 <= din.last;
			blk_s1  <= nxt;
		end
	end

	assign dout = '{vld: vld_s1, last: last_s1, blk: blk_s1};

endmodule

// ----- hdl/aes256_ecb_decrypt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes256_ecb_decrypt
// AES-256 ECB decryptor, fifteen-stage pipeline, key from four registers.
// ----------------------------------------------------------------------------
// One item enters per cycle unless the output stalls or the keys are being
// rebuilt, and passes one register stage for the initial key add and one
// for each of the 14 rounds. A stall on the output freezes the whole
// pipeline. After reset and every key write the round keys are rebuilt one
// 32-bit word per cycle, 60 words, and the input is not ready meanwhile.
module aes256_ecb_decrypt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_wdata,
	aesd_in_if.sink     cipher,
	aesd_out_if.source  plain
);

	logic             busy;
	logic             adv;
	aesd_pkg::blk_t   rkey [aesd_pkg::NR + 1];
	aesd_pkg::item_t  pipe [aesd_pkg::NR + 2];

	aesd_keyexp u_keyexp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.busy      (busy),
		.rkey      (rkey)
	);

	assign adv          = !pipe[aesd_pkg::NR + 1].vld || plain.ready;
	assign cipher.ready = adv && !busy;

	assign pipe[0] = '{vld: cipher.valid && !busy, last: cipher.last_block,
		blk: {cipher.cipher_high, cipher.cipher_low}};

	for (genvar k = 0; k <= aesd_pkg::NR; k++) begin : g_stage
		localparam aesd_pkg::rnd_kind_t KIND = (k == 0) ? aesd_pkg::RK_FIRST :
			((k == aesd_pkg::NR) ? aesd_pkg::RK_LAST : aesd_pkg::RK_MID);
		aesd_round u_round (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.kind   (KIND),
			.rkey   (rkey[aesd_pkg::NR - k]),
			.din    (pipe[k]),
			.dout   (pipe[k + 1])
		);
	end

	assign plain.valid      = pipe[aesd_pkg::NR + 1].vld;
	assign plain.last_out   = pipe[aesd_pkg::NR + 1].last;
	assign plain.plain_low  = pipe[aesd_pkg::NR + 1].blk[63:0];
	assign plain.plain_high = pipe[aesd_pkg::NR + 1].blk[127:64];

`ifndef SYNTHESIS
	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !cipher.ready)
		else $error("input ready during key schedule");
	a_cfg_starts_sched: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> busy)
		else $error("key write did not restart schedule");
	a_stall_holds_out: assert property (@(posedge clk) disable iff (!arst_n)
		(plain.valid && !plain.ready) |=> (plain.valid && $stable(plain.plain_low)))
		else $error("output item changed under stall");
	a_first_stage_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(pipe[1].vld))
		else $error("pipeline moved while stalled");
`endif

endmodule
